### rtl/inclinometer_frame_angle_decoder_defines.svh
// Assertion macros used by the RTL result queue.
`ifndef INCLINOMETER_FRAME_ANGLE_DECODER_DEFINES_SVH
`define INCLINOMETER_FRAME_ANGLE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define IFAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IFAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define IFAD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/ifad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifad_pkg;

    localparam int BUFFER_SIZE_DEF = 32;

    localparam logic [7:0] SYNC_BYTE = 8'h68;

    // frame position at which the length word arrives, and the angle words
    localparam int POS_LENGTH    = 1;
    localparam int POS_ANGLE_LO  = 4;
    localparam int POS_ANGLE_HI  = 6;

    localparam logic [3:0] SIGN_NEG = 4'h1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // length+1 needs 9 bits
    localparam int CMP_W = 9;

    localparam int ANGLE_W = 19;
    localparam int MAG_W   = 18;

    typedef struct packed {
        logic [7:0]  ang0;
        logic [7:0]  ang1;
        logic [7:0]  ang2;
        logic [7:0]  len;
        logic [15:0] cnt;
    } t_frame;

endpackage

`default_nettype wire

### rtl/ifad_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ifad_front #(
    parameter int BUFFER_SIZE = ifad_pkg::BUFFER_SIZE_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_rx_byte,
    output ifad_pkg::t_frame    o_frame,
    output logic                o_push
);

    localparam int PW = $clog2(BUFFER_SIZE + 1);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_len, n_len;
    logic          r_len_vld, n_len_vld;
    logic [7:0]    r_ang [3];
    logic [7:0]    n_ang [3];
    logic [15:0]   r_frames, n_frames;

    logic [PW-1:0] pos0;
    logic [PW-1:0] pos_inc;
    logic [1:0]    ang_idx;
    logic          done;

    always_comb begin
        pos0      = (i_rx_byte == ifad_pkg::SYNC_BYTE) ? '0 : r_pos;
        n_len     = r_len;
        n_len_vld = r_len_vld;
        n_ang     = r_ang;
        ang_idx   = 2'(pos0 - PW'(ifad_pkg::POS_ANGLE_LO));
        if (pos0 == PW'(ifad_pkg::POS_LENGTH)) begin
            n_len     = i_rx_byte;
            n_len_vld = 1'b1;
        end else if (pos0 >= PW'(ifad_pkg::POS_ANGLE_LO) &&
                     pos0 <= PW'(ifad_pkg::POS_ANGLE_HI)) begin
            n_ang[ang_idx] = i_rx_byte;
        end
        pos_inc = pos0 + PW'(1);
        done    = n_len_vld &&
                  (ifad_pkg::CMP_W'(pos_inc) == (ifad_pkg::CMP_W'(n_len) + 9'd1));
        // completing word skips the buffer-limit wrap
        if (done) begin
            n_pos = pos_inc;
        end else if (pos_inc >= PW'(BUFFER_SIZE - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc;
        end
        n_frames = done ? r_frames + 16'd1 : r_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_len_vld <= 1'b0;
            r_ang[0]  <= '0;
            r_ang[1]  <= '0;
            r_ang[2]  <= '0;
            r_frames  <= '0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_len_vld <= n_len_vld;
            r_ang     <= n_ang;
            r_frames  <= n_frames;
        end
    end

    assign o_push       = i_accept && done;
    assign o_frame.ang0 = n_ang[0];
    assign o_frame.ang1 = n_ang[1];
    assign o_frame.ang2 = n_ang[2];
    assign o_frame.len  = n_len;
    assign o_frame.cnt  = r_frames + 16'd1;

endmodule

`default_nettype wire

### rtl/ifad_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "inclinometer_frame_angle_decoder_defines.svh"

module ifad_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ifad_pkg::t_frame  i_frame,
    input  wire logic              i_pop,
    output ifad_pkg::t_frame       o_frame,
    output logic                   o_valid,
    output logic                   o_full
);

    ifad_pkg::t_frame                  r_mem [ifad_pkg::QUEUE_DEPTH];
    logic [ifad_pkg::QUEUE_AW-1:0]     r_wr;
    logic [ifad_pkg::QUEUE_AW-1:0]     r_rd;
    logic [ifad_pkg::QUEUE_CW-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + ifad_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + ifad_pkg::QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + ifad_pkg::QUEUE_CW'(1);
                2'b01:   r_count <= r_count - ifad_pkg::QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_frame = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == ifad_pkg::QUEUE_CW'(ifad_pkg::QUEUE_DEPTH));

    `IFAD_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `IFAD_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> o_valid, "pop from empty queue")
    `IFAD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= ifad_pkg::QUEUE_CW'(ifad_pkg::QUEUE_DEPTH), "queue count overrun")
    `IFAD_ASSERT(a_count_step, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + ifad_pkg::QUEUE_CW'(1)), "queue count missed a push")

endmodule

`default_nettype wire

### rtl/ifad_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ifad_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ifad_pkg::t_frame                    i_frame,
    input  wire logic                                i_q_valid,
    output logic                                     o_pop,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_stall,
    output logic signed [ifad_pkg::ANGLE_W-1:0]      o_angle_hundredths,
    output logic [7:0]                               o_frame_length,
    output logic [15:0]                              o_frame_count
);

    logic                              r_valid;
    logic [ifad_pkg::ANGLE_W-1:0]      r_angle;
    logic [7:0]                        r_len;
    logic [15:0]                       r_cnt;

    logic [3:0]                        sign;
    logic [10:0]                       int_part;
    logic [ifad_pkg::MAG_W-1:0]        mag;
    logic [ifad_pkg::ANGLE_W-1:0]      n_angle;
    logic                              load;

    // digits are raw nibbles, not checked as BCD
    always_comb begin
        sign     = i_frame.ang0[7:4];
        int_part = 11'(i_frame.ang0[3:0]) * 11'd100 +
                   11'(i_frame.ang1[7:4]) * 11'd10 +
                   11'(i_frame.ang1[3:0]);
        mag      = ifad_pkg::MAG_W'(int_part) * 18'd100 +
                   ifad_pkg::MAG_W'(i_frame.ang2[7:4]) * 18'd10 +
                   ifad_pkg::MAG_W'(i_frame.ang2[3:0]);
        if (sign == ifad_pkg::SIGN_NEG) begin
            n_angle = '0 - {1'b0, mag};
        end else begin
            n_angle = {1'b0, mag};
        end
    end

    assign load = i_q_valid && (!r_valid || !i_res_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_angle <= n_angle;
            r_len   <= i_frame.len;
            r_cnt   <= i_frame.cnt;
        end
    end

    assign o_pop              = load;
    assign o_res_valid        = r_valid;
    assign o_angle_hundredths = r_angle;
    assign o_frame_length     = r_len;
    assign o_frame_count      = r_cnt;

endmodule

`default_nettype wire

### rtl/inclinometer_frame_angle_decoder.sv
// A word that completes a frame is written to the result queue and from there loaded into the
// output register that raises o_res_valid; an earlier result still queued goes out first.
// Throughput: one word per cycle; o_rx_stall is high only while the two-entry result queue
// is full, which happens only after i_res_stall has held the output register.
// Reset: synchronous, active low; clears frame position, length, angle words, frame count,
// the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module inclinometer_frame_angle_decoder #(
    parameter int BUFFER_SIZE = ifad_pkg::BUFFER_SIZE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_rx_valid,
    output logic                                     o_rx_stall,
    input  wire logic [7:0]                          i_rx_byte,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_stall,
    output logic signed [ifad_pkg::ANGLE_W-1:0]      o_angle_hundredths,
    output logic [7:0]                               o_frame_length,
    output logic [15:0]                              o_frame_count
);

    ifad_pkg::t_frame  push_frame;
    ifad_pkg::t_frame  head_frame;
    logic              push;
    logic              pop;
    logic              q_valid;
    logic              q_full;
    logic              accept;

    assign o_rx_stall = q_full;
    assign accept     = i_rx_valid && !q_full;

    ifad_front #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_frame   (push_frame),
        .o_push    (push)
    );

    ifad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (head_frame),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    ifad_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_frame            (head_frame),
        .i_q_valid          (q_valid),
        .o_pop              (pop),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_angle_hundredths (o_angle_hundredths),
        .o_frame_length     (o_frame_length),
        .o_frame_count      (o_frame_count)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_WORDS    = 1750;
    localparam int SYNC_RUN_FRAMES = 200;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int FRAME_CAP       = 36;

    typedef struct {
        logic signed [ifad_pkg::ANGLE_W-1:0] angle;
        logic [7:0]                          len;
        logic [15:0]                         cnt;
    } t_frame_result;

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_rx_valid  = 1'b0;
    logic [7:0]                          i_rx_byte   = 8'h00;
    logic                                i_res_stall = 1'b0;
    logic                                o_rx_stall;
    logic                                o_res_valid;
    logic signed [ifad_pkg::ANGLE_W-1:0] o_angle_hundredths;
    logic [7:0]                          o_frame_length;
    logic [15:0]                         o_frame_count;

    // decoder shadow state
    int            rx_pos      = 0;
    logic [7:0]    rx_len      = 8'h00;
    bit            rx_len_ok   = 1'b0;
    logic [7:0]    ang_word[3] = '{default: 8'h00};
    logic [15:0]   frames_seen = 16'h0000;
    t_frame_result pending_frames[$];

    int mismatches  = 0;
    int words_sent  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    inclinometer_frame_angle_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_valid         (i_rx_valid),
        .o_rx_stall         (o_rx_stall),
        .i_rx_byte          (i_rx_byte),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_angle_hundredths (o_angle_hundredths),
        .o_frame_length     (o_frame_length),
        .o_frame_count      (o_frame_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void track_rx_byte(input logic [7:0] b);
        t_frame_result r;
        int            mag;
        if (b == ifad_pkg::SYNC_BYTE) rx_pos = 0;
        if (rx_pos == ifad_pkg::POS_LENGTH) begin
            rx_len    = b;
            rx_len_ok = 1'b1;
        end else if (rx_pos >= ifad_pkg::POS_ANGLE_LO && rx_pos <= ifad_pkg::POS_ANGLE_HI) begin
            ang_word[rx_pos - ifad_pkg::POS_ANGLE_LO] = b;
        end
        rx_pos++;
        if (rx_len_ok && rx_pos == int'(rx_len) + 1) begin
            frames_seen++;
            // nibbles taken as raw digits, no BCD check
            mag = 100 * (100 * int'(ang_word[0][3:0]) + 10 * int'(ang_word[1][7:4])
                         + int'(ang_word[1][3:0]))
                  + 10 * int'(ang_word[2][7:4]) + int'(ang_word[2][3:0]);
            if (ang_word[0][7:4] == ifad_pkg::SIGN_NEG) mag = -mag;
            r.angle = mag[ifad_pkg::ANGLE_W-1:0];
            r.len   = rx_len;
            r.cnt   = frames_seen;
            pending_frames.push_back(r);
        end else if (rx_pos >= ifad_pkg::BUFFER_SIZE_DEF - 1) begin
            rx_pos = 0;
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 55) return 0;
        return idle_len();
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == ifad_pkg::SYNC_BYTE);
        return b;
    endfunction

    function automatic logic [3:0] digit();
        if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, 9));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] sign_word();
        int         r;
        logic [3:0] s;
        r = $urandom_range(0, 99);
        if (r < 40)      s = 4'h0;
        else if (r < 80) s = ifad_pkg::SIGN_NEG;
        else             s = 4'($urandom_range(0, 15));
        return {s, digit()};
    endfunction

    task automatic put_rx_byte(input logic [7:0] b);
        int gap;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        track_rx_byte(b);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sync word, length, then positions up to last_pos
    task automatic put_frame(input logic [7:0] len, input logic [7:0] a0, input logic [7:0] a1,
                             input logic [7:0] a2, input int last_pos);
        for (int p = 0; p <= last_pos; p++) begin
            case (p)
                0:                          put_rx_byte(ifad_pkg::SYNC_BYTE);
                ifad_pkg::POS_LENGTH:       put_rx_byte(len);
                ifad_pkg::POS_ANGLE_LO:     put_rx_byte(a0);
                ifad_pkg::POS_ANGLE_LO + 1: put_rx_byte(a1);
                ifad_pkg::POS_ANGLE_HI:     put_rx_byte(a2);
                default:                    put_rx_byte(body_byte());
            endcase
        end
    endtask

    // no completion before a length word; then a short frame decodes the cleared angle
    task automatic test_startup();
        put_rx_byte(8'h3C);
        put_frame(8'd2, 8'h00, 8'h00, 8'h00, 2);
    endtask

    task automatic test_angle_extremes();
        put_frame(8'd6, 8'h1F, 8'hFF, 8'hFF, 6);
        put_frame(8'd6, 8'h0F, 8'hFF, 8'hFF, 6);
        put_frame(8'd6, 8'h10, 8'h00, 8'h00, 6);
    endtask

    // zero length survives the next sync word, which then completes at once
    task automatic test_kept_length();
        put_frame(8'd0, 8'h00, 8'h00, 8'h00, 1);
        put_rx_byte(ifad_pkg::SYNC_BYTE);
        put_rx_byte(ifad_pkg::SYNC_BYTE);
    endtask

    task automatic test_random_frames();
        int start, r, len, last;
        start = words_sent;
        while (words_sent < start + RANDOM_WORDS) begin
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                repeat ($urandom_range(1, 8))
                    put_rx_byte(($urandom_range(0, 3) == 0) ? ifad_pkg::SYNC_BYTE
                                                            : 8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(0, 99);
                if (len < 70)      len = $urandom_range(6, 12);
                else if (len < 92) len = $urandom_range(0, 30);
                else               len = $urandom_range(31, 255);
                last = (len > FRAME_CAP) ? FRAME_CAP : len;
                if (r < 20) last = $urandom_range(0, last);
                put_frame(8'(len), sign_word(), {digit(), digit()}, {digit(), digit()}, last);
            end
        end
        quiet = 1'b0;
    endtask

    // with a zero length every sync word completes a frame: results back to back while quiet
    task automatic test_sync_run();
        put_frame(8'd0, 8'h00, 8'h00, 8'h00, 1);
        for (int n = 0; n < SYNC_RUN_FRAMES; n++) begin
            if (n % 64 == 0) quiet = !quiet;
            put_rx_byte(ifad_pkg::SYNC_BYTE);
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (quiet) begin
            i_res_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 99) < 65) begin
            i_res_stall <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            i_res_stall <= 1'b1;
            stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected result word: angle %0d length %0d count %0d",
                       o_angle_hundredths, o_frame_length, o_frame_count);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                if (o_angle_hundredths !== want.angle) begin
                    $error("angle_hundredths: expected %0d, got %0d",
                           want.angle, o_angle_hundredths);
                    mismatches++;
                end
                if (o_frame_length !== want.len) begin
                    $error("frame_length: expected %0d, got %0d", want.len, o_frame_length);
                    mismatches++;
                end
                if (o_frame_count !== want.cnt) begin
                    $error("frame_count: expected %0d, got %0d", want.cnt, o_frame_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_startup();
        test_angle_extremes();
        test_kept_length();
        test_random_frames();
        test_sync_run();
        i_rx_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ifad_pkg.sv
rtl/ifad_front.sv
rtl/ifad_queue.sv
rtl/ifad_back.sv
rtl/inclinometer_frame_angle_decoder.sv
tb/sv/tb_top.sv
